### hdl/idpf_pkg.sv
// ----------------------------------------------------------------------------
// idpf_pkg
// Shared types and constants of the induced-dipole pair force pipeline.
// ----------------------------------------------------------------------------
package idpf_pkg;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 1;

  localparam logic [CfgIdxW-1:0] CFG_NEWTON_MODE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_USE_CHARGE  = 1'd1;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] SAT64   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [46:0] MAG47   = 47'h7FFF_FFFF_FFFF;

  localparam int DivSteps = 64;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic signed [31:0] owner_charge;
    logic [16:0]        special_factor;
    logic [31:0]        pair_strength;
    logic [31:0]        pair_core_sq;
    logic [31:0]        pair_cutoff_sq;
    logic               neighbour_local;
  } in_t;

  typedef struct packed {
    logic               in_cutoff;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic signed [47:0] force_scale;
    logic signed [47:0] pair_energy;
    logic               apply_to_neighbour;
  } out_t;

  typedef struct packed {
    logic [2:0][31:0] dm;
    logic [2:0]       neg;
    logic             inc;
    logic             nl;
  } side_t;

  function automatic logic [47:0] pack48(input logic [46:0] mag, input logic neg);
    logic [47:0] v;
    v = {1'b0, mag};
    return neg ? (48'd0 - v) : v;
  endfunction

endpackage

### hdl/idpf_qmul.sv
// ----------------------------------------------------------------------------
// idpf_qmul
// Two-stage Q32.32 saturating multiplier built from four 32x32 partials.
// ----------------------------------------------------------------------------
module idpf_qmul import idpf_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] full;
  logic [63:0]  p_d, p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= a_i[31:0]  * b_i[31:0];
      p01_q <= a_i[31:0]  * b_i[63:32];
      p10_q <= a_i[63:32] * b_i[31:0];
      p11_q <= a_i[63:32] * b_i[63:32];
      p_q   <= p_d;
    end
  end

  always_comb begin
    full = {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
         + {p11_q, 64'd0};
    p_d  = (|full[127:96]) ? SAT64 : full[95:32];
  end

  assign p_o = p_q;

endmodule

### hdl/idpf_qdiv.sv
// ----------------------------------------------------------------------------
// idpf_qdiv
// Pipelined restoring Q32.32 divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module idpf_qdiv import idpf_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o
);

  logic [63:0] rem_q [DivSteps];
  logic [63:0] lq_q  [DivSteps];
  logic [63:0] den_q [DivSteps];
  logic        sat_q [DivSteps];
  logic [63:0] rem_d [DivSteps];
  logic [63:0] lq_d  [DivSteps];

  always_comb begin
    logic [63:0] r;
    logic [63:0] l;
    logic [63:0] d;
    logic [64:0] w;
    for (int i = 0; i < DivSteps; i++) begin
      if (i == 0) begin
        r = {32'd0, num_i[63:32]};
        l = {num_i[31:0], 32'd0};
        d = den_i;
      end else begin
        r = rem_q[i-1];
        l = lq_q[i-1];
        d = den_q[i-1];
      end
      w = {r, l[63]};
      l = {l[62:0], 1'b0};
      if (w >= {1'b0, d}) begin
        w = w - {1'b0, d};
        l[0] = 1'b1;
      end
      rem_d[i] = w[63:0];
      lq_d[i]  = l;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DivSteps; i++) begin
        rem_q[i] <= rem_d[i];
        lq_q[i]  <= lq_d[i];
      end
      den_q[0] <= den_i;
      sat_q[0] <= ({32'd0, num_i[63:32]} >= den_i);
      for (int i = 1; i < DivSteps; i++) begin
        den_q[i] <= den_q[i-1];
        sat_q[i] <= sat_q[i-1];
      end
    end
  end

  assign quo_o = sat_q[DivSteps-1] ? SAT64 : lq_q[DivSteps-1];

endmodule

### hdl/induced_dipole_pair_force.sv
// ----------------------------------------------------------------------------
// induced_dipole_pair_force
// Induced-dipole pair force and energy, a neighbour pair per unstalled cycle.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
//   out     | output    | out_valid_o/ out_stall_i| out_data_o (out_t)
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One transaction enters per cycle unless the output stalls.
// The reciprocal and the ratio are formed by two 64-stage dividers.
// Reset clears the valid bits and sets both mode registers to one.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module induced_dipole_pair_force import idpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int Latency = 79;
  localparam int SideLen = 76;
  localparam int CLen    = 68;

  logic en;
  logic newton_q, charge_q;
  logic [Latency-1:0] vld_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newton_q <= 1'b1;
      charge_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEWTON_MODE: newton_q <= cfg_data_i[0];
        CFG_USE_CHARGE:  charge_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_valid_i};
    end
  end

  logic [2:0][31:0] dm1_d;
  logic [2:0]       neg1_d;
  logic [31:0]      qm1_d;
  always_comb begin
    logic [2:0][31:0] v;
    v[0] = in_data_i.disp_x;
    v[1] = in_data_i.disp_y;
    v[2] = in_data_i.disp_z;
    for (int i = 0; i < 3; i++) begin
      neg1_d[i] = v[i][31];
      dm1_d[i]  = v[i][31] ? (32'd0 - v[i]) : v[i];
    end
    qm1_d = in_data_i.owner_charge[31] ? (32'd0 - in_data_i.owner_charge)
                                       : in_data_i.owner_charge;
  end

  logic [2:0][31:0] dm1_q, dm2_q;
  logic [2:0]       neg1_q, neg2_q;
  logic [31:0]      qm1_q;
  logic [48:0]      kf1_q, kf2_q;
  logic [47:0]      cut1_q, cut2_q, p1_q, p2_q, p3_q;
  logic             nl1_q, nl2_q;
  logic [2:0][63:0] sq2_q;
  logic [63:0]      q2_q, s3_q;
  side_t            side_q [SideLen];
  side_t            side_d;

  always_comb begin
    logic [65:0] s;
    s = {2'd0, sq2_q[0]} + {2'd0, sq2_q[1]} + {2'd0, sq2_q[2]};
    side_d.dm  = dm2_q;
    side_d.neg = neg2_q;
    side_d.inc = (s < {18'd0, cut2_q});
    side_d.nl  = nl2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm1_q  <= dm1_d;
      neg1_q <= neg1_d;
      qm1_q  <= qm1_d;
      kf1_q  <= in_data_i.pair_strength * in_data_i.special_factor;
      cut1_q <= {in_data_i.pair_cutoff_sq, 16'd0};
      p1_q   <= {in_data_i.pair_core_sq, 16'd0};
      nl1_q  <= in_data_i.neighbour_local;
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= dm1_q[i] * dm1_q[i];
      end
      q2_q   <= charge_q ? (qm1_q * qm1_q) : ONE_Q32;
      kf2_q  <= kf1_q;
      cut2_q <= cut1_q;
      p2_q   <= p1_q;
      dm2_q  <= dm1_q;
      neg2_q <= neg1_q;
      nl2_q  <= nl1_q;
      s3_q   <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      p3_q   <= p2_q;
      side_q[0] <= side_d;
      for (int i = 1; i < SideLen; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic [63:0] c4;
  logic [63:0] c_q [CLen];
  idpf_qmul u_mul_c (.clk_i, .en_i(en), .a_i({15'd0, kf2_q}), .b_i(q2_q), .p_o(c4));

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0] <= c4;
      for (int i = 1; i < CLen; i++) begin
        c_q[i] <= c_q[i-1];
      end
    end
  end

  logic [63:0] inv67, u67;
  idpf_qdiv u_div_inv (.clk_i, .en_i(en), .num_i(ONE_Q32), .den_i(s3_q), .quo_o(inv67));
  idpf_qdiv u_div_u (.clk_i, .en_i(en), .num_i({16'd0, p3_q}), .den_i(s3_q), .quo_o(u67));

  logic [63:0] inv2_69, u4a_69, inv3_71, u4_71;
  logic [63:0] inv_d_q [2];
  logic [63:0] inv2_d_q [2];
  idpf_qmul u_mul_inv2 (.clk_i, .en_i(en), .a_i(inv67), .b_i(inv67), .p_o(inv2_69));
  idpf_qmul u_mul_u2 (.clk_i, .en_i(en), .a_i(u67), .b_i(u67), .p_o(u4a_69));
  idpf_qmul u_mul_inv3 (.clk_i, .en_i(en), .a_i(inv2_69), .b_i(inv_d_q[1]), .p_o(inv3_71));
  idpf_qmul u_mul_u4 (.clk_i, .en_i(en), .a_i(u4a_69), .b_i(u4a_69), .p_o(u4_71));

  logic [63:0] me_d, mf_d;
  logic        eneg_d, fneg_d;
  always_comb begin
    logic [65:0] t3;
    logic [63:0] t;
    t3     = {2'd0, u4_71} + {1'b0, u4_71, 1'b0};
    t      = (|t3[65:64]) ? SAT64 : t3[63:0];
    eneg_d = u4_71 < ONE_Q32;
    me_d   = eneg_d ? (ONE_Q32 - u4_71) : (u4_71 - ONE_Q32);
    fneg_d = t < ONE_Q32;
    mf_d   = fneg_d ? (ONE_Q32 - t) : (t - ONE_Q32);
  end

  logic [63:0] inv2_72_q, inv3_72_q;
  logic [63:0] me_q [3];
  logic [63:0] mf_q [3];
  logic [1:0]  sgn_q [5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_d_q[0]  <= inv67;
      inv_d_q[1]  <= inv_d_q[0];
      inv2_d_q[0] <= inv2_69;
      inv2_d_q[1] <= inv2_d_q[0];
      inv2_72_q   <= inv2_d_q[1];
      inv3_72_q   <= inv3_71;
      me_q[0]     <= me_d;
      mf_q[0]     <= mf_d;
      sgn_q[0]    <= {eneg_d, fneg_d};
      for (int i = 1; i < 3; i++) begin
        me_q[i] <= me_q[i-1];
        mf_q[i] <= mf_q[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        sgn_q[i] <= sgn_q[i-1];
      end
    end
  end

  logic [63:0] e1_74, f1_74, e_76, f_76;
  idpf_qmul u_mul_e1 (.clk_i, .en_i(en), .a_i(c_q[CLen-1]), .b_i(inv2_72_q), .p_o(e1_74));
  idpf_qmul u_mul_f1 (.clk_i, .en_i(en), .a_i(c_q[CLen-1]), .b_i(inv3_72_q), .p_o(f1_74));
  idpf_qmul u_mul_e (.clk_i, .en_i(en), .a_i(e1_74), .b_i(me_q[2]), .p_o(e_76));
  idpf_qmul u_mul_f (.clk_i, .en_i(en), .a_i(f1_74), .b_i(mf_q[2]), .p_o(f_76));

  logic [46:0] fs_d, em_d;
  always_comb begin
    logic [63:0] f4;
    f4   = (|f_76[63:62]) ? SAT64 : {f_76[61:0], 2'b00};
    fs_d = f4[63] ? MAG47 : f4[62:16];
    em_d = e_76[63] ? MAG47 : e_76[62:16];
  end

  logic [46:0] fs77_q, em77_q, fs78_q, em78_q;
  logic [1:0]  sgn77_q, sgn78_q;
  logic [2:0][63:0] plo78_q;
  logic [2:0][46:0] phi78_q;
  out_t        out_q, out_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fs77_q  <= fs_d;
      em77_q  <= em_d;
      sgn77_q <= sgn_q[4];
      for (int i = 0; i < 3; i++) begin
        plo78_q[i] <= side_q[SideLen-2].dm[i] * fs77_q[31:0];
        phi78_q[i] <= side_q[SideLen-2].dm[i] * fs77_q[46:32];
      end
      fs78_q  <= fs77_q;
      em78_q  <= em77_q;
      sgn78_q <= sgn77_q;
      out_q   <= out_d;
    end
  end

  always_comb begin
    logic [79:0]      full;
    logic [2:0][46:0] cm;
    side_t            sd;
    sd = side_q[SideLen-1];
    for (int i = 0; i < 3; i++) begin
      full  = {16'd0, plo78_q[i]} + {1'b0, phi78_q[i], 32'd0};
      cm[i] = (|full[79:63]) ? MAG47 : full[62:16];
    end
    out_d = '0;
    if (sd.inc) begin
      out_d.in_cutoff          = 1'b1;
      out_d.force_x            = pack48(cm[0], sd.neg[0] != sgn78_q[0]);
      out_d.force_y            = pack48(cm[1], sd.neg[1] != sgn78_q[0]);
      out_d.force_z            = pack48(cm[2], sd.neg[2] != sgn78_q[0]);
      out_d.force_scale        = pack48(fs78_q, sgn78_q[0]);
      out_d.pair_energy        = pack48(em78_q, sgn78_q[1]);
      out_d.apply_to_neighbour = newton_q | sd.nl;
    end
  end

  assign out_data_o = out_q;

endmodule
